[hdl/gttf_pkg.sv]
// Package for the grey threshold tile filter: shared types and fixed constants.
// Used by gttf_luma, grey_threshold_tile_filter and gttf_checker.
`timescale 1ns / 1ps

package gttf_pkg;

  // Pixel and grey arithmetic
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 22;   // max weighted sum 4186112 fits in 22 bits
  localparam int GREY_SHIFT = 14;
  localparam logic [SUM_W-1:0] COEF_B   = SUM_W'(1868);
  localparam logic [SUM_W-1:0] COEF_G   = SUM_W'(9617);
  localparam logic [SUM_W-1:0] COEF_R   = SUM_W'(4899);
  localparam logic [SUM_W-1:0] GREY_RND = SUM_W'(8192);

  // Configuration register widths and reset values
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int GEOM_W     = 13;
  localparam logic [GEOM_W-1:0] TILE_W_RST  = GEOM_W'(224);
  localparam logic [GEOM_W-1:0] TILE_H_RST  = GEOM_W'(224);
  localparam logic [GEOM_W-1:0] IMAGE_W_RST = GEOM_W'(1024);
  localparam logic [PIX_W-1:0]  THRESH_RST  = PIX_W'(80);

  // Result field widths
  localparam int ROW_W  = 12;
  localparam int TCOL_W = 6;
  localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(4095);

  // Stream packing
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_DONE_BIT = 24;
  localparam int OUT_KEEP_BIT = 25;
  localparam int OUT_USED_W   = 44;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_WIDTH     = 2'd0,
    REG_TILE_HEIGHT    = 2'd1,
    REG_IMAGE_WIDTH    = 2'd2,
    REG_GREY_THRESHOLD = 2'd3
  } cfg_reg_t;

  // Per-pixel grey decision passed from the luma unit
  typedef struct packed {
    logic dark;    // grey below threshold, pixel is blacked out
    logic bright;  // grey at or above max(threshold, 1)
  } luma_t;

endpackage

[hdl/gttf_luma.sv]
// Grey conversion of one BGR pixel and its threshold decisions.
// Depends on gttf_pkg.
`timescale 1ns / 1ps

module gttf_luma import gttf_pkg::*; (
  input  logic [PIX_W-1:0] blue,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] threshold,
  output luma_t            res
);

  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] grey;
  logic [PIX_W-1:0] level;

  // Weighted sum with rounding, then drop the fraction bits
  assign sum  = SUM_W'(blue) * COEF_B + SUM_W'(green) * COEF_G
              + SUM_W'(red) * COEF_R + GREY_RND;
  assign grey = PIX_W'(sum >> GREY_SHIFT);

  // Tile brightness uses a level of at least one
  assign level = (threshold == '0) ? PIX_W'(1) : threshold;

  assign res.dark   = (grey < threshold);
  assign res.bright = (grey >= level);

endmodule

[hdl/grey_threshold_tile_filter.sv]
// Grey threshold tile filter: one result per pixel; each input transaction passes through
// the input register and then the result register before its result transaction.
// One pixel per cycle sustained while out_tready is high; a result stall holds the
// input once the input register is full. Synchronous active-low reset clears counters,
// valids and configuration (224x224 tiles, 1024 wide, threshold 80). Tile flag memory
// is not cleared; frame_start restarts tiling. Depends on gttf_pkg and gttf_luma.
`timescale 1ns / 1ps

module grey_threshold_tile_filter import gttf_pkg::*; #(
  parameter int MAX_TILE_COLS = 64,
  parameter int MAX_DIM       = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic [IN_USER_W-1:0]  in_tuser,   // frame_start[0]
  // Result output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_blue[7:0], out_green[15:8],
                                            // out_red[23:16], tile_done[24],
                                            // tile_keep[25], tile_row[37:26],
                                            // tile_col[43:38], zero[47:44]
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int COL_W  = $clog2(MAX_TILE_COLS + 1);
  localparam int ADDR_W = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int PROD_W = COL_W + DIM_W;

  // Configuration registers
  logic [GEOM_W-1:0] tile_width_r, tile_height_r, image_width_r;
  logic [PIX_W-1:0]  grey_threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r     <= TILE_W_RST;
      tile_height_r    <= TILE_H_RST;
      image_width_r    <= IMAGE_W_RST;
      grey_threshold_r <= THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TILE_WIDTH:     tile_width_r     <= GEOM_W'(cfg_data);
        REG_TILE_HEIGHT:    tile_height_r    <= GEOM_W'(cfg_data);
        REG_IMAGE_WIDTH:    image_width_r    <= GEOM_W'(cfg_data);
        REG_GREY_THRESHOLD: grey_threshold_r <= PIX_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Clamp geometry into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [GEOM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0)
      r = DIM_W'(1);
    else if (32'(v) > MAX_DIM)
      r = DIM_W'(MAX_DIM);
    else
      r = DIM_W'(v);
    return r;
  endfunction

  logic [DIM_W-1:0] tw_c, th_c, iw_c;
  assign tw_c = clamp_dim(tile_width_r);
  assign th_c = clamp_dim(tile_height_r);
  assign iw_c = clamp_dim(image_width_r);

  // Input register stage
  logic                 s1_valid_r;
  logic [PIX_W-1:0]     s1_blue_r, s1_green_r, s1_red_r;
  logic                 s1_fs_r;
  logic                 adv;

  assign adv       = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_blue_r  <= in_tdata[7:0];
      s1_green_r <= in_tdata[15:8];
      s1_red_r   <= in_tdata[23:16];
      s1_fs_r    <= in_tuser[0];
    end
  end

  // Grey value and threshold decisions
  luma_t luma;

  gttf_luma u_luma (
    .blue      (s1_blue_r),
    .green     (s1_green_r),
    .red       (s1_red_r),
    .threshold (grey_threshold_r),
    .res       (luma)
  );

  // Position counters
  logic [CNT_W-1:0] col_cnt_r, x_r, y_r;
  logic [COL_W-1:0] tcol_r;
  logic [ROW_W-1:0] trow_r;
  logic [CNT_W-1:0] col_cnt_nxt, x_nxt, y_nxt;
  logic [COL_W-1:0] tcol_nxt;
  logic [ROW_W-1:0] trow_nxt;

  // Counters as seen by this pixel; frame_start restarts at the top left
  logic [CNT_W-1:0] cc_e, x_e, y_e;
  logic [COL_W-1:0] col_e;
  logic [ROW_W-1:0] row_e;

  assign cc_e  = s1_fs_r ? '0 : col_cnt_r;
  assign x_e   = s1_fs_r ? '0 : x_r;
  assign y_e   = s1_fs_r ? '0 : y_r;
  assign col_e = s1_fs_r ? '0 : tcol_r;
  assign row_e = s1_fs_r ? '0 : trow_r;

  logic [DIM_W-1:0]  cc1, x1, y1;
  logic              end_x, end_y, end_row;
  logic              stored, fits, first, flag, done;
  logic [PROD_W-1:0] tile_right;
  logic              flag_prev;

  assign cc1 = DIM_W'(cc_e) + DIM_W'(1);
  assign x1  = DIM_W'(x_e) + DIM_W'(1);
  assign y1  = DIM_W'(y_e) + DIM_W'(1);

  assign end_x   = (x1 >= tw_c);
  assign end_y   = (y1 >= th_c);
  assign end_row = (cc1 >= iw_c);

  // A tile is reported only when its right edge lies within the row
  assign stored     = (col_e < COL_W'(MAX_TILE_COLS));
  assign tile_right = (PROD_W'(col_e) + PROD_W'(1)) * PROD_W'(tw_c);
  assign fits       = (tile_right <= PROD_W'(iw_c));

  // Running "all bright" flag for the current tile column
  assign first = (x_e == '0) && (y_e == '0);
  assign flag  = first ? luma.bright : (flag_prev && luma.bright);
  assign done  = stored && fits && end_x && end_y;

  // Next counter values
  always_comb begin
    col_cnt_nxt = cc_e;
    x_nxt       = x_e;
    y_nxt       = y_e;
    tcol_nxt    = col_e;
    trow_nxt    = row_e;
    if (end_row) begin
      col_cnt_nxt = '0;
      x_nxt       = '0;
      tcol_nxt    = '0;
      if (end_y) begin
        y_nxt = '0;
        if (row_e < ROW_LIMIT)
          trow_nxt = row_e + ROW_W'(1);
      end else begin
        y_nxt = CNT_W'(y1);
      end
    end else begin
      col_cnt_nxt = CNT_W'(cc1);
      if (end_x) begin
        x_nxt = '0;
        if (stored)
          tcol_nxt = col_e + COL_W'(1);
      end else begin
        x_nxt = CNT_W'(x1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      x_r       <= '0;
      y_r       <= '0;
      tcol_r    <= '0;
      trow_r    <= '0;
    end else if (adv) begin
      col_cnt_r <= col_cnt_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      tcol_r    <= tcol_nxt;
      trow_r    <= trow_nxt;
    end
  end

  // Tile flag memory: written at this pixel's column, read ahead at the next one
  logic                  flag_mem [MAX_TILE_COLS];
  logic                  flag_rd_r;
  logic                  byp_r;
  logic                  byp_val_r;
  logic                  flag_wr;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;

  assign flag_wr = adv && stored;
  assign wr_addr = col_e[ADDR_W-1:0];
  assign rd_addr = tcol_nxt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (flag_wr)
      flag_mem[wr_addr] <= flag;
    if (adv)
      flag_rd_r <= flag_mem[rd_addr];
  end

  // Forward a flag written in the same cycle as its read
  always_ff @(posedge clk) begin
    if (adv) begin
      byp_r     <= flag_wr && (tcol_nxt == col_e);
      byp_val_r <= flag;
    end
  end

  assign flag_prev = byp_r ? byp_val_r : flag_rd_r;

  // Result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  always_comb begin
    out_data_nxt                = '0;
    out_data_nxt[7:0]           = luma.dark ? '0 : s1_blue_r;
    out_data_nxt[15:8]          = luma.dark ? '0 : s1_green_r;
    out_data_nxt[23:16]         = luma.dark ? '0 : s1_red_r;
    out_data_nxt[OUT_DONE_BIT]  = done;
    out_data_nxt[OUT_KEEP_BIT]  = done && flag;
    out_data_nxt[37:26]         = done ? row_e : '0;
    out_data_nxt[43:38]         = done ? TCOL_W'(col_e) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv)
      out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/gttf_checker.sv]
// Port-level checks for the grey threshold tile filter, bound to the top level.
// Depends on gttf_pkg and grey_threshold_tile_filter.
`timescale 1ns / 1ps

module gttf_checker import gttf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // Reset leaves no result transaction pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Input is held off only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with no result waiting");

  // Tile fields are zero unless a tile completes
  a_tile_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_DONE_BIT] |-> out_tdata[OUT_USED_W-1:OUT_KEEP_BIT] == '0)
    else $error("tile fields set without tile_done");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
    else $error("nonzero padding in result");

endmodule

bind grey_threshold_tile_filter gttf_checker u_gttf_checker (.*);
